// File: hdl/wdsip_pkg.sv
package wdsip_pkg;

  localparam int unsigned DurW  = 32;
  localparam int unsigned StepW = 10;
  localparam int unsigned CodeW = 4;
  localparam int unsigned ActW  = 2;
  localparam int unsigned NapN  = 7;

  localparam logic [StepW-1:0] ShortestNap = StepW'(15);

  typedef logic [ActW-1:0] action_t;
  localparam action_t ActNap   = 2'd0;
  localparam action_t ActDelay = 2'd1;
  localparam action_t ActDone  = 2'd2;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdDone  = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_NAP    = 4'b0010,
    PH_MAKEUP = 4'b0100,
    PH_FINAL  = 4'b1000
  } phase_t;

  // Nap ladder, longest first
  typedef logic [StepW-1:0] step_t;
  typedef logic [CodeW-1:0] code_t;

  localparam step_t NapLen [NapN] = '{
    step_t'(1000), step_t'(500), step_t'(250), step_t'(120),
    step_t'(60),   step_t'(30),  step_t'(15)
  };
  localparam code_t NapCode [NapN] = '{
    code_t'(6), code_t'(5), code_t'(4), code_t'(3),
    code_t'(2), code_t'(1), code_t'(0)
  };

  typedef struct packed {
    action_t act;
    code_t   code;
    step_t   ms;
  } result_t;

endpackage

// File: hdl/watchdog_sleep_interval_planner.sv
// Watchdog sleep interval planner.
//
// Input stream (in_*): one word per event. in_tuser[0] is the command
// (0 = start a new plan, 1 = previous action done), in_tuser[1] says the
// finished nap ended by the watchdog. in_tdata carries the duration in ms,
// read on start only.
// Output stream (out_*): exactly one word per input word. out_tuser is the
// action (0 = watchdog nap, 1 = timer delay, 2 = finished), out_tdata holds
// the prescaler code and the action length in ms.
//
// The answer for an accepted word is registered and presented from the
// cycle after it is accepted. Throughput is one word per cycle while the
// receiver takes each word, set by the single compare ladder and subtract
// between the plan state and the output register.
// Reset leaves the planner idle with nothing planned and no word pending.
// When the receiver stalls, the output register holds its word and
// in_tready drops until that word is taken; the plan state advances only
// on accepted words.
module watchdog_sleep_interval_planner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] duration_ms
  input  logic [1:0]  in_tuser,   // [0] command, [1] woke_by_watchdog
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] prescaler_code, [13:4] action_ms, [15:14] zero
  output logic [1:0]  out_tuser   // [1:0] action
);
  import wdsip_pkg::*;

  logic              in_fire;
  logic              cmd;
  logic              by_wdt;
  logic [DurW-1:0]   src_ms;
  logic [NapN-1:0]   fits;

  logic [DurW-1:0]   remaining_r, remaining_nxt;
  phase_t            phase_r, phase_nxt;
  step_t             pending_r, pending_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           res_r, res_nxt;

  result_t           plan_res;
  logic [DurW-1:0]   plan_rem;
  phase_t            plan_phase;
  step_t             plan_pending;

  assign cmd     = in_tuser[0];
  assign by_wdt  = in_tuser[1];
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire = in_tvalid && in_tready;
  assign src_ms  = (cmd == CmdStart) ? in_tdata : remaining_r;

  always_comb begin
    for (int k = 0; k < NapN; k++) begin
      fits[k] = (src_ms >= DurW'(NapLen[k]));
    end
  end

  // Next action from the new duration on a start, else from what is left of the plan
  always_comb begin
    plan_res     = '{act: ActDone, code: '0, ms: '0};
    plan_rem     = src_ms;
    plan_phase   = PH_IDLE;
    plan_pending = '0;
    if (src_ms >= DurW'(ShortestNap)) begin
      plan_phase = PH_NAP;
      for (int k = NapN - 1; k >= 0; k--) begin
        if (fits[k]) begin
          plan_res     = '{act: ActNap, code: NapCode[k], ms: NapLen[k]};
          plan_pending = NapLen[k];
          plan_rem     = src_ms - DurW'(NapLen[k]);
        end
      end
    end else if (src_ms != '0) begin
      plan_res   = '{act: ActDelay, code: '0, ms: src_ms[StepW-1:0]};
      plan_rem   = '0;
      plan_phase = PH_FINAL;
    end
  end

  always_comb begin
    remaining_nxt = remaining_r;
    phase_nxt     = phase_r;
    pending_nxt   = pending_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      if (cmd == CmdStart) begin
        remaining_nxt = plan_rem;
        phase_nxt     = plan_phase;
        pending_nxt   = plan_pending;
        res_nxt       = plan_res;
      end else begin
        case (phase_r)
          PH_NAP: begin
            if (!by_wdt) begin
              // make up the nap with a busy delay of the same length
              phase_nxt = PH_MAKEUP;
              res_nxt   = '{act: ActDelay, code: '0, ms: pending_r};
            end else begin
              remaining_nxt = plan_rem;
              phase_nxt     = plan_phase;
              pending_nxt   = plan_pending;
              res_nxt       = plan_res;
            end
          end
          PH_MAKEUP: begin
            remaining_nxt = plan_rem;
            phase_nxt     = plan_phase;
            pending_nxt   = plan_pending;
            res_nxt       = plan_res;
          end
          PH_FINAL: begin
            phase_nxt   = PH_IDLE;
            pending_nxt = '0;
            res_nxt     = '{act: ActDone, code: '0, ms: '0};
          end
          default: begin
            res_nxt = '{act: ActDone, code: '0, ms: '0};
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      phase_r     <= PH_IDLE;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      remaining_r <= remaining_nxt;
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.act;
  assign out_tdata  = {2'b00, res_r.ms, res_r.code};

  a_idle_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_FINAL) |-> remaining_r == '0)
    else $error("nothing may remain planned when idle or in the final delay");

  a_nap_pending : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NAP || phase_r == PH_MAKEUP) |-> pending_r >= ShortestNap)
    else $error("outstanding nap has no length");

  a_answer : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no answer");

  a_nap_code : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.act == ActNap) |-> (res_r.code < code_t'(NapN) &&
      res_r.ms >= ShortestNap && phase_r == PH_NAP))
    else $error("nap answer inconsistent with plan state");

  a_done_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.act == ActDone) |-> (res_r.ms == '0 && phase_r == PH_IDLE))
    else $error("finished answer with a length or a live plan");

endmodule

// File: verif/sleep_plan_checker.sv
module sleep_plan_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [31:0]        in_tdata,   // [31:0] duration_ms
  input  logic [1:0]         in_tuser,   // [0] command, [1] woke_by_watchdog
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [15:0]        out_tdata,  // [3:0] prescaler_code, [13:4] action_ms, [15:14] zero
  input  logic [1:0]         out_tuser,  // [1:0] action
  output int unsigned        errors,
  output int unsigned        pending,
  output int unsigned        naps_seen,
  output int unsigned        delays_seen,
  output int unsigned        finished_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import wdsip_pkg::*;

  localparam code_t Wdt15ms  = 4'd0;
  localparam code_t Wdt30ms  = 4'd1;
  localparam code_t Wdt60ms  = 4'd2;
  localparam code_t Wdt120ms = 4'd3;
  localparam code_t Wdt250ms = 4'd4;
  localparam code_t Wdt500ms = 4'd5;
  localparam code_t Wdt1s    = 4'd6;
  localparam code_t NoCode   = 4'd0;

  localparam step_t StepTable [7] = '{
    step_t'(1000), step_t'(500), step_t'(250), step_t'(120),
    step_t'(60), step_t'(30), step_t'(15)
  };
  localparam code_t CodeTable [7] = '{
    Wdt1s, Wdt500ms, Wdt250ms, Wdt120ms, Wdt60ms, Wdt30ms, Wdt15ms
  };

  logic [DurW-1:0] unplanned_ms;
  phase_t          plan_phase;
  step_t           nap_in_flight_ms;
  result_t         planned_actions [$];

  // Take the longest nap that fits, a final delay for a short leftover,
  // or report the plan finished.
  function automatic result_t next_planned_action();
    result_t r;
    int      pick;
    pick = 6;
    if (unplanned_ms >= 32'd15) begin
      for (int k = 6; k >= 0; k--) begin
        if (unplanned_ms >= DurW'(StepTable[k])) pick = k;
      end
      unplanned_ms     = unplanned_ms - DurW'(StepTable[pick]);
      nap_in_flight_ms = StepTable[pick];
      plan_phase       = PH_NAP;
      r = '{act: ActNap, code: CodeTable[pick], ms: StepTable[pick]};
    end else if (unplanned_ms != '0) begin
      r = '{act: ActDelay, code: NoCode, ms: step_t'(unplanned_ms)};
      unplanned_ms     = '0;
      nap_in_flight_ms = '0;
      plan_phase       = PH_FINAL;
    end else begin
      nap_in_flight_ms = '0;
      plan_phase       = PH_IDLE;
      r = '{act: ActDone, code: NoCode, ms: '0};
    end
    return r;
  endfunction

  function automatic result_t advance_plan(logic cmd, logic [DurW-1:0] dur, logic woke);
    result_t r;
    r = '{act: ActDone, code: NoCode, ms: '0};
    if (cmd == CmdStart) begin
      unplanned_ms = dur;
      r = next_planned_action();
    end else begin
      case (plan_phase)
        PH_NAP: begin
          if (!woke) begin
            plan_phase = PH_MAKEUP;
            r = '{act: ActDelay, code: NoCode, ms: nap_in_flight_ms};
          end else begin
            r = next_planned_action();
          end
        end
        PH_MAKEUP: begin
          r = next_planned_action();
        end
        PH_FINAL: begin
          plan_phase       = PH_IDLE;
          nap_in_flight_ms = '0;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      unplanned_ms     = '0;
      plan_phase       = PH_IDLE;
      nap_in_flight_ms = '0;
      planned_actions.delete();
      errors        = 0;
      naps_seen     = 0;
      delays_seen   = 0;
      finished_seen = 0;
    end else begin
      // the word leaving now always belongs to an earlier input word
      if (out_tvalid && out_tready) begin
        if (planned_actions.size() == 0) begin
          $error("result word with none expected: tuser %0h tdata %0h", out_tuser, out_tdata);
          errors++;
        end else begin
          want = planned_actions.pop_front();
          check_field("action", 32'(want.act), 32'(out_tuser));
          check_field("prescaler_code", 32'(want.code), 32'(out_tdata[3:0]));
          check_field("action_ms", 32'(want.ms), 32'(out_tdata[13:4]));
          check_field("pad", 32'd0, 32'(out_tdata[15:14]));
          case (want.act)
            ActNap:   naps_seen++;
            ActDelay: delays_seen++;
            default:  finished_seen++;
          endcase
        end
      end
      if (in_tvalid && in_tready) begin
        planned_actions.push_back(advance_plan(in_tuser[0], in_tdata, in_tuser[1]));
      end
    end
    pending = planned_actions.size();
  end

endmodule

// File: verif/watchdog_sleep_interval_planner_tb.sv
module watchdog_sleep_interval_planner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wdsip_pkg::*;

  localparam int ItemsWanted = 1100;
  localparam int LongHold    = 300;
  localparam int DrainLimit  = 2000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] duration_ms
  logic [1:0]  in_tuser   = '0;   // [0] command, [1] woke_by_watchdog
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [3:0] prescaler_code, [13:4] action_ms, [15:14] zero
  logic [1:0]  out_tuser;         // [1:0] action

  int unsigned errors, pending, naps_seen, delays_seen, finished_seen;
  int unsigned words_sent = 0;
  int unsigned starts_sent = 0;
  int unsigned long_holds = 0;
  bit          stall_req = 1'b0;
  bit          no_gaps = 1'b0;

  watchdog_sleep_interval_planner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sleep_plan_checker plan_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .errors        (errors),
    .pending       (pending),
    .naps_seen     (naps_seen),
    .delays_seen   (delays_seen),
    .finished_seen (finished_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 2100);
    if (r < 60) return $urandom_range(0, 20);
    if (r < 72) return $urandom_range(990, 1010);
    if (r < 82) return $urandom_range(1, 4) * 1000 + $urandom_range(0, 16);
    if (r < 88) return 32'hFFFF_FFF0 + $urandom_range(0, 15);
    return $urandom();
  endfunction

  task automatic send_word(input logic cmd, input logic [31:0] dur, input logic woke);
    int gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= dur;
    in_tuser  <= {woke, cmd};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (cmd == CmdStart) starts_sent++;
  endtask

  // receiver: random stalls, the odd free-running stretch, and one long hold-off on request
  initial begin
    int run_len, gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        long_holds++;
        out_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 24);
      out_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int          done_words;
    int          drain_cycles;
    logic [31:0] dur;
    bit          drain_timeout;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // done while idle, both wake flags
    send_word(CmdDone, 32'h0, 1'b0);
    send_word(CmdDone, 32'hFFFF_FFFF, 1'b1);
    // zero duration
    send_word(CmdStart, 32'd0, 1'b0);
    // leftover below the shortest nap, then finish, then done while idle
    send_word(CmdStart, 32'd14, 1'b1);
    send_word(CmdDone, 32'd0, 1'b0);
    send_word(CmdDone, 32'd0, 1'b1);
    // shortest nap cut short: make-up delay, then finished
    send_word(CmdStart, 32'd15, 1'b0);
    send_word(CmdDone, 32'd0, 1'b0);
    send_word(CmdDone, 32'd0, 1'b0);
    // every step of the ladder once, then a final delay of 7 ms
    send_word(CmdStart, 32'd1982, 1'b0);
    repeat (8) send_word(CmdDone, 32'd0, 1'b1);
    send_word(CmdDone, 32'd0, 1'b1);
    // largest duration, interrupted by a fresh start
    send_word(CmdStart, 32'hFFFF_FFFF, 1'b0);
    send_word(CmdDone, 32'h0, 1'b0);
    send_word(CmdStart, 32'd1, 1'b0);
    send_word(CmdDone, 32'd0, 1'b0);

    while (words_sent < ItemsWanted) begin
      dur = pick_duration();
      no_gaps = ($urandom_range(0, 99) < 15);
      if (stall_req == 1'b0 && long_holds == 0 && words_sent > ItemsWanted / 2) begin
        stall_req = 1'b1;
      end
      send_word(CmdStart, dur, 1'($urandom_range(0, 1)));
      // long plans get cut off by the next start; short ones mostly run out
      done_words = (dur > 32'd5000) ? $urandom_range(0, 8) : $urandom_range(1, 30);
      repeat (done_words) begin
        send_word(CmdDone, $urandom(), ($urandom_range(0, 9) < 7));
      end
    end
    in_tvalid <= 1'b0;

    drain_cycles = 0;
    @(negedge clk);
    while (pending != 0 && drain_cycles < DrainLimit) begin
      @(negedge clk);
      drain_cycles++;
    end
    drain_timeout = (pending != 0);
    repeat (4) @(negedge clk);

    $display("run: %0d words in (%0d plan starts), %0d long receiver hold-off(s)",
             words_sent, starts_sent, long_holds);
    $display("run: %0d naps, %0d timer delays, %0d finished reports checked",
             naps_seen, delays_seen, finished_seen);
    if (drain_timeout || errors != 0) begin
      $display("tb: failure");
    end else begin
      $display("tb: success");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/wdsip_pkg.sv
hdl/watchdog_sleep_interval_planner.sv
verif/sleep_plan_checker.sv
verif/watchdog_sleep_interval_planner_tb.sv
